// File: sv/wcmt_pkg.sv
// Shared types and constants for the windowed commit mark tracker.
package wcmt_pkg;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned SUB_W    = 4;
    localparam int unsigned POS_W    = 48;
    localparam int unsigned MARK_W   = 47;
    localparam int unsigned SAMP_W   = 31;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned CFG_AW   = 3;
    localparam int unsigned CFG_DW   = 47;
    localparam int unsigned IN_DW    = 56;
    localparam int unsigned OUT_DW   = 112;
    localparam int unsigned OUT_UW   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_COMMIT    = 3'd0,
        CMD_ADOPT     = 3'd1,
        CMD_RESET_ONE = 3'd2,
        CMD_RESET_ALL = 3'd3,
        CMD_CLEAR     = 3'd4
    } t_cmd;

    localparam logic [CFG_AW-1:0] REG_BOUND_ENABLE    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_SUBTRACK_COUNT  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_CAPACITY        = 3'd2;
    localparam logic [CFG_AW-1:0] REG_REEL_SAMPLES    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_LINEAR_TOPOLOGY = 3'd4;
    localparam logic [CFG_AW-1:0] REG_WINDOW_ORIGIN   = 3'd5;

endpackage

// File: sv/wcmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wcmt_ram #(
    parameter int unsigned WIDTH = 47,
    parameter int unsigned DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/windowed_commit_mark_tracker.sv
// Committed high-water mark tracker for a tape stored as a window onto a longer reel.
//
// Usage:
//   Commands enter on the s_axis stream (command in tuser, sub-track and up_to
//   in tdata) and each produces exactly one result on the m_axis stream
//   (accepted and fill_valid in tuser, fill offset, fill length and new mark in
//   tdata). Configuration registers are written through a plain write port
//   (enable, index, data) only while no request is in flight; the user must keep
//   this rule, the block does not enforce it. A write to the bound register
//   clears every mark. A request is registered in the work stage, where the mark
//   RAM read arrives, then in the result register. Throughput is one request per
//   cycle unless the receiver stalls: the mark store is read when a request is
//   accepted and written back when it leaves the work stage, and a bypass
//   register covers a read that meets that write back. Reset clears all marks
//   (per-entry valid bits), the pipeline and the config registers to their
//   defaults; the mark RAM itself needs no clearing pass. When the receiver
//   stalls, the result register holds, the work stage holds its request, and
//   s_axis_tready drops once both are occupied; nothing is lost or repeated.
module windowed_commit_mark_tracker
    import wcmt_pkg::*;
#(
    parameter int unsigned MAX_SUBTRACKS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DW-1:0]     s_axis_tdata,   // [3:0] subtrack, [51:4] up_to, [55:52] zero
    input  logic [CMD_W-1:0]     s_axis_tuser,   // [2:0] command
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_DW-1:0]    m_axis_tdata,   // [30:0] fill_offset, [61:31] fill_length,
                                                 // [108:62] new_mark, [111:109] zero
    output logic [OUT_UW-1:0]    m_axis_tuser,   // [0] accepted, [1] fill_valid
    // configuration write port
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_AW-1:0]    i_cfg_addr,
    input  logic [CFG_DW-1:0]    i_cfg_wr_data
);

    localparam int unsigned AW = (MAX_SUBTRACKS > 1) ? $clog2(MAX_SUBTRACKS) : 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic               r_bound;
    logic [COUNT_W-1:0] r_sub_count;
    logic [SAMP_W-1:0]  r_capacity;
    logic [MARK_W-1:0]  r_reel;
    logic               r_linear;
    logic [MARK_W-1:0]  r_origin;
    logic               cfg_bound_wr;

    assign cfg_bound_wr = i_cfg_wr_en && (i_cfg_addr == REG_BOUND_ENABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound     <= 1'b0;
            r_sub_count <= COUNT_W'(1);
            r_capacity  <= SAMP_W'(1);
            r_reel      <= '0;
            r_linear    <= 1'b0;
            r_origin    <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_BOUND_ENABLE:    r_bound     <= i_cfg_wr_data[0];
                REG_SUBTRACK_COUNT:  r_sub_count <= i_cfg_wr_data[COUNT_W-1:0];
                REG_CAPACITY:        r_capacity  <= i_cfg_wr_data[SAMP_W-1:0];
                REG_REEL_SAMPLES:    r_reel      <= i_cfg_wr_data[MARK_W-1:0];
                REG_LINEAR_TOPOLOGY: r_linear    <= i_cfg_wr_data[0];
                REG_WINDOW_ORIGIN:   r_origin    <= i_cfg_wr_data[MARK_W-1:0];
                default: ;
            endcase
        end
    end

    // Window end (exclusive) and reel length, both config-only.
    logic [POS_W-1:0]  win_end;
    logic [MARK_W-1:0] reel_len;

    assign win_end = {1'b0, r_origin} + {{(POS_W-SAMP_W){1'b0}}, r_capacity};

    always_comb begin
        if (!r_bound) begin
            reel_len = '0;
        end else if (r_linear && (r_reel > {{(MARK_W-SAMP_W){1'b0}}, r_capacity})) begin
            reel_len = r_reel;
        end else begin
            reel_len = {{(MARK_W-SAMP_W){1'b0}}, r_capacity};
        end
    end

    // ---------------------------------------------------------------
    // Input side: clamp the target before it meets the mark
    // ---------------------------------------------------------------
    logic                in_fire;
    logic                s1_fire;
    logic [SUB_W-1:0]    in_sub;
    logic [POS_W-1:0]    in_up_to;
    logic [SUB_W+AW-1:0] in_sub_ext;
    logic [AW-1:0]       in_addr;
    logic [POS_W-1:0]    n_tgt;
    logic [POS_W-1:0]    n_to;

    assign in_sub     = s_axis_tdata[SUB_W-1:0];
    assign in_up_to   = s_axis_tdata[SUB_W+POS_W-1:SUB_W];
    assign in_sub_ext = {{AW{1'b0}}, in_sub};
    assign in_addr    = in_sub_ext[AW-1:0];

    always_comb begin
        if ($signed(in_up_to) < $signed({1'b0, reel_len})) begin
            n_tgt = in_up_to;
        end else begin
            n_tgt = {1'b0, reel_len};
        end
        // upper end of the commit span, clipped to the window
        n_to = (n_tgt < win_end) ? n_tgt : win_end;
    end

    logic               r_s1_valid;
    t_cmd               r_cmd;
    logic [SUB_W-1:0]   r_sub;
    logic [AW-1:0]      r_addr;
    logic               r_tgt_neg;
    logic [MARK_W-1:0]  r_tgt;
    logic [POS_W-1:0]   r_to;

    logic               r_out_valid;

    assign s1_fire       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd     <= t_cmd'(s_axis_tuser);
            r_sub     <= in_sub;
            r_addr    <= in_addr;
            r_tgt_neg <= n_tgt[POS_W-1];
            r_tgt     <= n_tgt[MARK_W-1:0];
            r_to      <= n_to;
        end
    end

    // ---------------------------------------------------------------
    // Mark store: RAM plus per-entry valid bits and a write-back bypass
    // ---------------------------------------------------------------
    logic                     wr_en;
    logic [MARK_W-1:0]        wr_data;
    logic                     clear_all;
    logic [MARK_W-1:0]        ram_q;
    logic [MAX_SUBTRACKS-1:0] r_valid;
    logic                     r_fwd_valid;
    logic [AW-1:0]            r_fwd_addr;
    logic [MARK_W-1:0]        r_fwd_data;

    wcmt_ram #(
        .WIDTH (MARK_W),
        .DEPTH (MAX_SUBTRACKS)
    ) u_mark_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (in_fire),
        .i_rd_addr (in_addr),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear_all || cfg_bound_wr) begin
            r_valid     <= '0;
            r_fwd_valid <= 1'b0;
        end else if (wr_en) begin
            r_valid[r_addr] <= 1'b1;
            r_fwd_valid     <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fwd_addr <= r_addr;
            r_fwd_data <= wr_data;
        end
    end

    // ---------------------------------------------------------------
    // Work stage: apply the command to the current mark
    // ---------------------------------------------------------------
    logic [MARK_W-1:0] mark;
    logic              index_ok;
    logic              raise;
    logic [MARK_W-1:0] from;
    logic [POS_W-1:0]  commit_len;
    logic [MARK_W-1:0] commit_off;
    logic [POS_W-1:0]  top;
    logic [POS_W-1:0]  clear_len;

    logic              n_acc;
    logic              n_fv;
    logic [SAMP_W-1:0] n_off;
    logic [SAMP_W-1:0] n_len;
    logic [MARK_W-1:0] n_mark;

    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == r_addr)) begin
            mark = r_fwd_data;
        end else if (r_valid[r_addr]) begin
            mark = ram_q;
        end else begin
            mark = '0;
        end
    end

    assign index_ok = r_bound
                   && ({1'b0, r_sub} < r_sub_count)
                   && (32'(r_sub) < MAX_SUBTRACKS);
    assign raise    = !r_tgt_neg && (r_tgt > mark);

    // commit span: from max(mark, origin) up to the clipped target
    assign from       = (mark > r_origin) ? mark : r_origin;
    assign commit_off = from - r_origin;
    assign commit_len = r_to - {1'b0, from};

    // clear span: resident part below the mark
    assign top       = ({1'b0, mark} < win_end) ? {1'b0, mark} : win_end;
    assign clear_len = top - {1'b0, r_origin};

    always_comb begin
        n_acc     = 1'b0;
        n_fv      = 1'b0;
        n_off     = '0;
        n_len     = '0;
        n_mark    = '0;
        wr_en     = 1'b0;
        wr_data   = '0;
        clear_all = 1'b0;
        case (r_cmd)
            CMD_COMMIT, CMD_ADOPT: begin
                if (index_ok) begin
                    n_acc  = 1'b1;
                    n_mark = mark;
                    if (raise) begin
                        wr_en   = s1_fire;
                        wr_data = r_tgt;
                        n_mark  = r_tgt;
                        if ((r_cmd == CMD_COMMIT) && (r_to > {1'b0, from})) begin
                            n_fv  = 1'b1;
                            n_off = commit_off[SAMP_W-1:0];
                            n_len = commit_len[SAMP_W-1:0];
                        end
                    end
                end
            end
            CMD_RESET_ONE: begin
                if (index_ok) begin
                    n_acc = 1'b1;
                    wr_en = s1_fire;
                end
            end
            CMD_RESET_ALL: begin
                n_acc     = r_bound;
                clear_all = s1_fire && r_bound;
            end
            CMD_CLEAR: begin
                if (index_ok) begin
                    n_acc  = 1'b1;
                    n_mark = mark;
                    if (top > {1'b0, r_origin}) begin
                        n_fv  = 1'b1;
                        n_len = clear_len[SAMP_W-1:0];
                    end
                end
            end
            default: ;  // undefined command: reject, no change
        endcase
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic              r_acc;
    logic              r_fv;
    logic [SAMP_W-1:0] r_off;
    logic [SAMP_W-1:0] r_len;
    logic [MARK_W-1:0] r_mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_acc  <= n_acc;
            r_fv   <= n_fv;
            r_off  <= n_off;
            r_len  <= n_len;
            r_mark <= n_mark;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_fv, r_acc};
    assign m_axis_tdata  = {{(OUT_DW-MARK_W-2*SAMP_W){1'b0}}, r_mark, r_len, r_off};

endmodule
